[src/cstp_pkg.sv]
`default_nettype none

package cstp_pkg;

    // Longest word that is still parsed; longer words are skipped whole.
    localparam int MAX_WORD = 511;
    // Word and value counters must hold MAX_WORD + 1.
    localparam int WL_W     = $clog2(MAX_WORD + 2);
    localparam int NUM_W    = 15;
    localparam int PROD_W   = NUM_W + 4;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    localparam int NUM_KEYS = 5;
    localparam int NUM_VALS = 7;

    localparam logic [NUM_W-1:0] NUM_SAT = {NUM_W{1'b1}};
    localparam logic [NUM_W-1:0] PCT_MAX = NUM_W'(100);
    localparam logic [6:0]       PCT7_MAX = 7'd100;
    localparam logic [1:0]       VERT_MAX = 2'd2;
    localparam logic [2:0]       ALIGN_MAX = 3'd4;

    // Key indexes.
    localparam int K_ALIGN    = 0;
    localparam int K_LINE     = 1;
    localparam int K_POSITION = 2;
    localparam int K_SIZE     = 3;
    localparam int K_VERTICAL = 4;

    // Value word indexes; the align words come first, then the vertical words.
    localparam int V_LR = 5;
    localparam int V_RL = 6;
    localparam logic [NUM_VALS-1:0] VAL_ALIGN_SET = 7'b0011111;
    localparam logic [NUM_VALS-1:0] VAL_VERT_SET  = 7'b1100000;

    localparam logic [1:0] VERT_LR = 2'd1;
    localparam logic [1:0] VERT_RL = 2'd2;

    // Byte codes.
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_LINE     = 3'd0;
    localparam logic [2:0] REG_SNAP     = 3'd1;
    localparam logic [2:0] REG_POSITION = 3'd2;
    localparam logic [2:0] REG_SIZE     = 3'd3;
    localparam logic [2:0] REG_VERTICAL = 3'd4;
    localparam logic [2:0] REG_ALIGN    = 3'd5;

    // Reset values of the default registers and the settings.
    localparam logic signed [15:0] RST_LINE     = -16'sd1;
    localparam logic               RST_SNAP     = 1'b1;
    localparam logic [6:0]         RST_POSITION = 7'd50;
    localparam logic [6:0]         RST_SIZE     = 7'd100;
    localparam logic [1:0]         RST_VERTICAL = 2'd0;
    localparam logic [2:0]         RST_ALIGN    = 3'd1;

    localparam logic signed [15:0] LINE_MIN_RAW = 16'sh8000;
    localparam logic signed [15:0] LINE_MIN     = -16'sd32767;

    typedef enum logic [1:0] {
        PH_GAP,
        PH_KEY,
        PH_VALUE,
        PH_SKIP
    } t_phase;

    typedef struct packed {
        logic       func;
        logic [7:0] char_byte;
        logic       last;
    } t_cue_in;

    typedef struct packed {
        logic signed [15:0] out_line;
        logic               out_snap;
        logic [6:0]         out_size;
        logic [6:0]         out_position;
        logic [1:0]         out_vertical;
        logic [2:0]         out_align;
    } t_cue_out;

    function automatic logic [3:0] key_len(input logic [2:0] k);
        logic [3:0] len;
        case (k)
            3'd0:    len = 4'd5;
            3'd1:    len = 4'd4;
            3'd2:    len = 4'd8;
            3'd3:    len = 4'd4;
            3'd4:    len = 4'd8;
            default: len = 4'd0;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] key_char(input logic [2:0] k, input logic [2:0] p);
        logic [63:0] txt;
        case (k)
            3'd0:    txt = {"align", 24'h0};
            3'd1:    txt = {"line", 32'h0};
            3'd2:    txt = "position";
            3'd3:    txt = {"size", 32'h0};
            3'd4:    txt = "vertical";
            default: txt = 64'h0;
        endcase
        return txt[63 - 8 * p -: 8];
    endfunction

    function automatic logic [3:0] val_len(input logic [2:0] v);
        logic [3:0] len;
        case (v)
            3'd0:    len = 4'd5;
            3'd1:    len = 4'd6;
            3'd2:    len = 4'd3;
            3'd3:    len = 4'd4;
            3'd4:    len = 4'd5;
            3'd5:    len = 4'd2;
            3'd6:    len = 4'd2;
            default: len = 4'd0;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] val_char(input logic [2:0] v, input logic [2:0] p);
        logic [63:0] txt;
        case (v)
            3'd0:    txt = {"start", 24'h0};
            3'd1:    txt = {"middle", 16'h0};
            3'd2:    txt = {"end", 40'h0};
            3'd3:    txt = {"left", 32'h0};
            3'd4:    txt = {"right", 24'h0};
            3'd5:    txt = {"lr", 48'h0};
            3'd6:    txt = {"rl", 48'h0};
            default: txt = 64'h0;
        endcase
        return txt[63 - 8 * p -: 8];
    endfunction

endpackage

`default_nettype wire

[src/cue_settings_text_parser.sv]
`default_nettype none

// Channel  | Direction | Handshake                  | Payload
// ---------+-----------+----------------------------+--------------------------------
// in       | input     | i_in_valid / o_in_stall    | i_in_data  (func, byte, last)
// out      | output    | o_out_valid / i_out_stall  | o_out_data (all six settings)
// config   | input     | psel/penable/pwrite/pready | paddr, pwdata, prdata
//
// One input transfer is taken every clock cycle when the output side keeps up.
// A transfer is held in the input register and parsed from there; when it
// carries last, its result is registered into the output register as it leaves.
// Reset is synchronous: it loads the default registers and the settings with
// their reset values and puts the parser between words.
// A stalled result holds up only an item that carries last; bytes before it keep flowing.

module cue_settings_text_parser (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    output logic                         o_in_stall,
    input  wire cstp_pkg::t_cue_in       i_in_data,
    output logic                         o_out_valid,
    input  wire                          i_out_stall,
    output cstp_pkg::t_cue_out           o_out_data,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire [cstp_pkg::ADDR_W-1:0]   paddr,
    input  wire [cstp_pkg::DATA_W-1:0]   pwdata,
    output logic [cstp_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);
    import cstp_pkg::*;

    // Default registers written through the configuration port.
    logic signed [15:0] r_def_line;
    logic               r_def_snap;
    logic [6:0]         r_def_position;
    logic [6:0]         r_def_size;
    logic [1:0]         r_def_vertical;
    logic [2:0]         r_def_align;

    // Current settings.
    logic signed [15:0] r_line, n_line;
    logic               r_snap, n_snap;
    logic [6:0]         r_size, n_size;
    logic [6:0]         r_position, n_position;
    logic [1:0]         r_vertical, n_vertical;
    logic [2:0]         r_align, n_align;

    // Parser state.
    t_phase                r_phase, n_phase;
    logic [WL_W-1:0]       r_wlen, n_wlen;
    logic [NUM_KEYS-1:0]   r_kc, n_kc;
    logic [NUM_VALS-1:0]   r_vc, n_vc;
    logic [WL_W-1:0]       r_vi, n_vi;
    logic                  r_dig, n_dig;
    logic [NUM_W-1:0]      r_acc, n_acc;
    logic                  r_minus, n_minus;
    logic                  r_pct, n_pct;

    // Input register and output register.
    logic     r_in_valid;
    t_cue_in  r_in;
    logic     r_out_valid;
    t_cue_out r_out;

    logic cfg_write;
    logic out_free;
    logic fire;
    logic accept;

    // Working values for the byte in the input register.
    logic [7:0]          ch;
    logic                is_space;
    logic                is_digit;
    t_phase              s_phase, w_phase;
    logic [WL_W-1:0]     s_wlen, w_wlen;
    logic [NUM_KEYS-1:0] s_kc, w_kc;
    logic [NUM_VALS-1:0] s_vc, w_vc;
    logic [WL_W-1:0]     s_vi, w_vi;
    logic                s_dig, w_dig;
    logic [NUM_W-1:0]    s_acc, w_acc;
    logic                s_minus, w_minus;
    logic                s_pct, w_pct;
    logic [NUM_KEYS-1:0] key_narrow;
    logic [NUM_KEYS-1:0] key_exact;
    logic [NUM_KEYS-1:0] key_first;
    logic [NUM_VALS-1:0] val_narrow;
    logic [PROD_W-1:0]   acc_prod;

    // Word-end check, fed either by the stored state (whitespace) or by the
    // state just updated with this byte (last byte of the string).
    logic                do_finish;
    t_phase              f_phase;
    logic [NUM_KEYS-1:0] f_kc;
    logic [NUM_VALS-1:0] f_vc;
    logic [WL_W-1:0]     f_vi;
    logic                f_dig;
    logic [NUM_W-1:0]    f_acc;
    logic                f_minus;
    logic                f_pct;
    logic                align_hit;
    logic [2:0]          align_code;
    logic signed [15:0]  acc_signed;
    logic signed [15:0]  def_line_clamped;

    // ------------------------------------------------------------------
    // Configuration port.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_def_line     <= RST_LINE;
            r_def_snap     <= RST_SNAP;
            r_def_position <= RST_POSITION;
            r_def_size     <= RST_SIZE;
            r_def_vertical <= RST_VERTICAL;
            r_def_align    <= RST_ALIGN;
        end else if (cfg_write) begin
            case (paddr[ADDR_W-1:2])
                REG_LINE:     r_def_line     <= $signed(pwdata[15:0]);
                REG_SNAP:     r_def_snap     <= pwdata[0];
                REG_POSITION: r_def_position <= pwdata[6:0];
                REG_SIZE:     r_def_size     <= pwdata[6:0];
                REG_VERTICAL: r_def_vertical <= pwdata[1:0];
                REG_ALIGN:    r_def_align    <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[ADDR_W-1:2])
            REG_LINE:     prdata = DATA_W'(r_def_line);
            REG_SNAP:     prdata = DATA_W'(r_def_snap);
            REG_POSITION: prdata = DATA_W'(r_def_position);
            REG_SIZE:     prdata = DATA_W'(r_def_size);
            REG_VERTICAL: prdata = DATA_W'(r_def_vertical);
            REG_ALIGN:    prdata = DATA_W'(r_def_align);
            default:      prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Handshakes. The parse stage moves on unless it holds a last byte and
    // the output register is still waiting for its transfer.
    // ------------------------------------------------------------------
    assign out_free    = !r_out_valid || !i_out_stall;
    assign fire        = r_in_valid && (!r_in.last || out_free);
    assign o_in_stall  = r_in_valid && !fire;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_in_data;
        end
    end

    // ------------------------------------------------------------------
    // Byte parsing: key and value matching, number accumulation, phase.
    // ------------------------------------------------------------------
    assign ch       = r_in.char_byte;
    assign is_space = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_LF) ||
                      (ch == CH_FF) || (ch == CH_CR);
    assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);

    always_comb begin
        // A byte that opens a word sees freshly cleared word state.
        s_phase = r_phase;
        s_wlen  = r_wlen;
        s_kc    = r_kc;
        s_vc    = r_vc;
        s_vi    = r_vi;
        s_dig   = r_dig;
        s_acc   = r_acc;
        s_minus = r_minus;
        s_pct   = r_pct;
        if (r_phase == PH_GAP) begin
            s_phase = PH_KEY;
            s_wlen  = '0;
            s_kc    = '1;
            s_vc    = '1;
            s_vi    = '0;
            s_dig   = 1'b0;
            s_acc   = '0;
            s_minus = 1'b0;
            s_pct   = 1'b0;
        end

        // The key position is the word length before this byte.
        for (int i = 0; i < NUM_KEYS; i++) begin
            key_narrow[i] = s_kc[i] && (s_wlen < WL_W'(key_len(3'(i)))) &&
                            (key_char(3'(i), s_wlen[2:0]) == ch);
            key_exact[i]  = s_kc[i] && (s_wlen == WL_W'(key_len(3'(i))));
        end
        key_first = '0;
        for (int i = NUM_KEYS - 1; i >= 0; i--) begin
            if (key_exact[i]) begin
                key_first    = '0;
                key_first[i] = 1'b1;
            end
        end
        for (int i = 0; i < NUM_VALS; i++) begin
            val_narrow[i] = s_vc[i] && (s_vi < WL_W'(val_len(3'(i)))) &&
                            (val_char(3'(i), s_vi[2:0]) == ch);
        end
        acc_prod = (PROD_W'(s_acc) << 3) + (PROD_W'(s_acc) << 1) +
                   PROD_W'(ch - CH_ZERO);

        w_phase = s_phase;
        w_wlen  = s_wlen;
        w_kc    = s_kc;
        w_vc    = s_vc;
        w_vi    = s_vi;
        w_dig   = s_dig;
        w_acc   = s_acc;
        w_minus = s_minus;
        w_pct   = s_pct;

        if (w_phase != PH_SKIP) begin
            w_wlen = s_wlen + 1'b1;
            if (w_wlen > WL_W'(MAX_WORD)) begin
                w_phase = PH_SKIP;
            end
        end

        case (w_phase)
            PH_KEY: begin
                if (ch == CH_COLON) begin
                    if ((s_wlen == '0) || (key_exact == '0)) begin
                        w_phase = PH_SKIP;
                    end else begin
                        w_kc    = key_first;
                        w_phase = PH_VALUE;
                        if (key_first[K_ALIGN]) begin
                            w_vc = VAL_ALIGN_SET;
                        end else if (key_first[K_VERTICAL]) begin
                            w_vc = VAL_VERT_SET;
                        end else begin
                            w_vc = '0;
                        end
                    end
                end else begin
                    w_kc = key_narrow;
                    if (key_narrow == '0) begin
                        w_phase = PH_SKIP;
                    end
                end
            end
            PH_VALUE: begin
                if (s_kc[K_ALIGN] || s_kc[K_VERTICAL]) begin
                    w_vc = val_narrow;
                    if (val_narrow == '0) begin
                        w_phase = PH_SKIP;
                    end
                end else if (s_pct) begin
                    // Nothing may follow the percent sign.
                    w_phase = PH_SKIP;
                end else if (is_digit) begin
                    w_dig = 1'b1;
                    w_acc = (acc_prod > PROD_W'(NUM_SAT)) ? NUM_SAT : acc_prod[NUM_W-1:0];
                end else if ((ch == CH_MINUS) && s_kc[K_LINE] && (s_vi == '0)) begin
                    w_minus = 1'b1;
                end else if ((ch == CH_PCT) && s_dig && !s_minus) begin
                    w_pct = 1'b1;
                end else begin
                    w_phase = PH_SKIP;
                end
                if (s_vi <= WL_W'(MAX_WORD)) begin
                    w_vi = s_vi + 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Next parser state. Whitespace, restore and the end of the string all
    // put the parser between words.
    always_comb begin
        n_phase = w_phase;
        n_wlen  = w_wlen;
        n_kc    = w_kc;
        n_vc    = w_vc;
        n_vi    = w_vi;
        n_dig   = w_dig;
        n_acc   = w_acc;
        n_minus = w_minus;
        n_pct   = w_pct;
        if (r_in.func || is_space) begin
            n_phase = PH_GAP;
            n_wlen  = r_wlen;
            n_kc    = r_kc;
            n_vc    = r_vc;
            n_vi    = r_vi;
            n_dig   = r_dig;
            n_acc   = r_acc;
            n_minus = r_minus;
            n_pct   = r_pct;
        end
        if (r_in.last) begin
            n_phase = PH_GAP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_GAP;
            r_wlen  <= '0;
            r_kc    <= '1;
            r_vc    <= '1;
            r_vi    <= '0;
            r_dig   <= 1'b0;
            r_acc   <= '0;
            r_minus <= 1'b0;
            r_pct   <= 1'b0;
        end else if (fire) begin
            r_phase <= n_phase;
            r_wlen  <= n_wlen;
            r_kc    <= n_kc;
            r_vc    <= n_vc;
            r_vi    <= n_vi;
            r_dig   <= n_dig;
            r_acc   <= n_acc;
            r_minus <= n_minus;
            r_pct   <= n_pct;
        end
    end

    // ------------------------------------------------------------------
    // Settings update: a finished word or a restore of the defaults.
    // ------------------------------------------------------------------
    assign do_finish = !r_in.func && (is_space || r_in.last);

    always_comb begin
        f_phase = is_space ? r_phase : w_phase;
        f_kc    = is_space ? r_kc    : w_kc;
        f_vc    = is_space ? r_vc    : w_vc;
        f_vi    = is_space ? r_vi    : w_vi;
        f_dig   = is_space ? r_dig   : w_dig;
        f_acc   = is_space ? r_acc   : w_acc;
        f_minus = is_space ? r_minus : w_minus;
        f_pct   = is_space ? r_pct   : w_pct;

        acc_signed = f_minus ? -$signed({1'b0, f_acc}) : $signed({1'b0, f_acc});

        align_hit  = 1'b0;
        align_code = '0;
        for (int i = V_LR - 1; i >= 0; i--) begin
            if (f_vc[i] && (f_vi == WL_W'(val_len(3'(i))))) begin
                align_hit  = 1'b1;
                align_code = 3'(i);
            end
        end

        def_line_clamped = (r_def_line == LINE_MIN_RAW) ? LINE_MIN : r_def_line;
    end

    always_comb begin
        n_line     = r_line;
        n_snap     = r_snap;
        n_size     = r_size;
        n_position = r_position;
        n_vertical = r_vertical;
        n_align    = r_align;

        if (r_in.func) begin
            // Each default is taken only if it is a legal setting.
            if (r_def_snap || ((def_line_clamped >= 16'sd0) &&
                               (def_line_clamped <= $signed({9'd0, PCT7_MAX})))) begin
                n_line = def_line_clamped;
                n_snap = r_def_snap;
            end
            if (r_def_position <= PCT7_MAX) begin
                n_position = r_def_position;
            end
            if (r_def_size <= PCT7_MAX) begin
                n_size = r_def_size;
            end
            if (r_def_vertical <= VERT_MAX) begin
                n_vertical = r_def_vertical;
            end
            if (r_def_align <= ALIGN_MAX) begin
                n_align = r_def_align;
            end
        end else if (do_finish && (f_phase == PH_VALUE) && (f_vi != '0)) begin
            if (f_kc[K_ALIGN]) begin
                if (align_hit) begin
                    n_align = align_code;
                end
            end else if (f_kc[K_VERTICAL]) begin
                if (f_vc[V_LR] && (f_vi == WL_W'(val_len(3'(V_LR))))) begin
                    n_vertical = VERT_LR;
                end else if (f_vc[V_RL] && (f_vi == WL_W'(val_len(3'(V_RL))))) begin
                    n_vertical = VERT_RL;
                end
            end else if (f_kc[K_LINE]) begin
                if (f_dig) begin
                    if (f_pct) begin
                        if (f_acc <= PCT_MAX) begin
                            n_line = $signed({1'b0, f_acc});
                            n_snap = 1'b0;
                        end
                    end else begin
                        n_line = acc_signed;
                        n_snap = 1'b1;
                    end
                end
            end else if (f_kc[K_SIZE] || f_kc[K_POSITION]) begin
                if (f_dig && f_pct && (f_acc <= PCT_MAX)) begin
                    if (f_kc[K_SIZE]) begin
                        n_size = f_acc[6:0];
                    end else begin
                        n_position = f_acc[6:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line     <= RST_LINE;
            r_snap     <= RST_SNAP;
            r_size     <= RST_SIZE;
            r_position <= RST_POSITION;
            r_vertical <= RST_VERTICAL;
            r_align    <= RST_ALIGN;
        end else if (fire) begin
            r_line     <= n_line;
            r_snap     <= n_snap;
            r_size     <= n_size;
            r_position <= n_position;
            r_vertical <= n_vertical;
            r_align    <= n_align;
        end
    end

    // ------------------------------------------------------------------
    // Output register: a last item hands over the updated settings.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && r_in.last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && r_in.last) begin
            r_out.out_line     <= n_line;
            r_out.out_snap     <= n_snap;
            r_out.out_size     <= n_size;
            r_out.out_position <= n_position;
            r_out.out_vertical <= n_vertical;
            r_out.out_align    <= n_align;
        end
    end

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_value_key_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_VALUE) |-> $onehot(r_kc))
        else $error("value phase without a single matched key");

    a_no_result_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !(fire && r_in.last))
        else $error("pending result overwritten");

    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_in.last) |=> (o_out_valid && (r_phase == PH_GAP)))
        else $error("last item did not produce a result");

    a_settings_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_size <= PCT7_MAX) && (r_position <= PCT7_MAX) &&
        (r_vertical <= VERT_MAX) && (r_align <= ALIGN_MAX) &&
        (r_snap || ((r_line >= 16'sd0) && (r_line <= $signed({9'd0, PCT7_MAX})))))
        else $error("setting out of its legal range");

endmodule

`default_nettype wire

[tb/cue_settings_text_parser_test.sv]
`timescale 1ns / 100ps

module cue_settings_text_parser_test;

    import cstp_pkg::*;

    // Codes outside the legal ranges, used to check that a restore skips them, and the align start code.
    localparam logic [1:0] VERT_BAD    = 2'd3;
    localparam logic [2:0] ALIGN_BAD   = 3'd7;
    localparam logic [2:0] ALIGN_START = 3'd0;
    localparam logic [6:0] PCT_BAD     = 7'd127;

    // Cycles to let pass after the last expected result, the receiver's long
    // hold-off, and the number of cycles without any transfer that ends the run.
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int STUCK_LIMIT  = 2000;

    // Tracks the settings the block should report. Every accepted input
    // transfer is run through a byte-level copy of the parser; an item that
    // carries last queues a snapshot of the settings, and each result transfer
    // is compared with the oldest snapshot.
    class cue_settings_tracker;
        string key_words[NUM_KEYS];
        string val_words[NUM_VALS];

        logic signed [15:0] dflt_line;
        logic               dflt_snap;
        logic [6:0]         dflt_position;
        logic [6:0]         dflt_size;
        logic [1:0]         dflt_vertical;
        logic [2:0]         dflt_align;

        int   line_now;
        logic snap_now;
        int   size_now;
        int   position_now;
        int   vertical_now;
        int   align_now;

        t_phase              phase;
        int                  word_len;
        int                  value_len;
        int                  digits;
        int                  number;
        logic [NUM_KEYS-1:0] keys_left;
        logic [NUM_VALS-1:0] vals_left;
        bit                  minus_seen;
        bit                  pct_seen;

        t_cue_out settings_due[$];
        int       faults;

        function new();
            key_words = '{"align", "line", "position", "size", "vertical"};
            val_words = '{"start", "middle", "end", "left", "right", "lr", "rl"};
            dflt_line     = RST_LINE;
            dflt_snap     = RST_SNAP;
            dflt_position = RST_POSITION;
            dflt_size     = RST_SIZE;
            dflt_vertical = RST_VERTICAL;
            dflt_align    = RST_ALIGN;
            line_now      = RST_LINE;
            snap_now      = RST_SNAP;
            position_now  = RST_POSITION;
            size_now      = RST_SIZE;
            vertical_now  = RST_VERTICAL;
            align_now     = RST_ALIGN;
            faults        = 0;
            open_word();
            phase = PH_GAP;
        endfunction

        function int pending();
            return settings_due.size();
        endfunction

        function void set_default(logic [2:0] idx, logic [31:0] data);
            case (idx)
                REG_LINE:     dflt_line     = data[15:0];
                REG_SNAP:     dflt_snap     = data[0];
                REG_POSITION: dflt_position = data[6:0];
                REG_SIZE:     dflt_size     = data[6:0];
                REG_VERTICAL: dflt_vertical = data[1:0];
                REG_ALIGN:    dflt_align    = data[2:0];
                default: ;
            endcase
        endfunction

        function bit is_blank(logic [7:0] c);
            return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_FF || c == CH_CR;
        endfunction

        function void open_word();
            phase      = PH_KEY;
            word_len   = 0;
            keys_left  = '1;
            vals_left  = '1;
            value_len  = 0;
            digits     = 0;
            number     = 0;
            minus_seen = 1'b0;
            pct_seen   = 1'b0;
        endfunction

        // Once the colon is seen exactly one key is left.
        function int key_now();
            for (int i = 0; i < NUM_KEYS; i++)
                if (keys_left[i])
                    return i;
            return -1;
        endfunction

        // Each default is taken only where it is a legal setting.
        function void restore();
            int l;
            l = dflt_line;
            if (l < -32767)
                l = -32767;
            if (dflt_snap || (l >= 0 && l <= 100)) begin
                line_now = l;
                snap_now = dflt_snap;
            end
            if (dflt_position <= 100)
                position_now = dflt_position;
            if (dflt_size <= 100)
                size_now = dflt_size;
            if (dflt_vertical <= VERT_MAX)
                vertical_now = dflt_vertical;
            if (dflt_align <= ALIGN_MAX)
                align_now = dflt_align;
        endfunction

        function void key_byte(logic [7:0] c, int pos);
            int                  k;
            logic [NUM_KEYS-1:0] keep;
            k = -1;
            keep = '0;
            if (c == CH_COLON) begin
                for (int i = 0; i < NUM_KEYS; i++)
                    if (k < 0 && keys_left[i] && key_words[i].len() == pos)
                        k = i;
                if (pos == 0 || k < 0) begin
                    phase = PH_SKIP;
                end else begin
                    keys_left = '0;
                    keys_left[k] = 1'b1;
                    vals_left = (k == K_ALIGN) ? VAL_ALIGN_SET :
                                (k == K_VERTICAL) ? VAL_VERT_SET : '0;
                    phase = PH_VALUE;
                end
            end else begin
                for (int i = 0; i < NUM_KEYS; i++)
                    if (keys_left[i] && pos < key_words[i].len() && key_words[i][pos] == c)
                        keep[i] = 1'b1;
                keys_left = keep;
                if (keep == '0)
                    phase = PH_SKIP;
            end
        endfunction

        function void value_byte(logic [7:0] c);
            int                  k;
            logic [NUM_VALS-1:0] keep;
            k = key_now();
            keep = '0;
            if (k == K_ALIGN || k == K_VERTICAL) begin
                for (int i = 0; i < NUM_VALS; i++)
                    if (vals_left[i] && value_len < val_words[i].len() &&
                        val_words[i][value_len] == c)
                        keep[i] = 1'b1;
                vals_left = keep;
                if (keep == '0)
                    phase = PH_SKIP;
            end else if (k == K_LINE || k == K_SIZE || k == K_POSITION) begin
                if (pct_seen) begin
                    phase = PH_SKIP;
                end else if (c >= CH_ZERO && c <= CH_NINE) begin
                    if (digits < 1023)
                        digits++;
                    number = number * 10 + int'(c - CH_ZERO);
                    if (number > 32767)
                        number = 32767;
                end else if (c == CH_MINUS && k == K_LINE && value_len == 0) begin
                    minus_seen = 1'b1;
                end else if (c == CH_PCT && digits != 0 && !minus_seen) begin
                    pct_seen = 1'b1;
                end else begin
                    phase = PH_SKIP;
                end
            end else begin
                phase = PH_SKIP;
            end
            if (value_len <= MAX_WORD)
                value_len++;
        endfunction

        // Applies a word that has passed its key's rules.
        function void close_word();
            int k;
            int m;
            if (phase != PH_VALUE || value_len == 0)
                return;
            k = key_now();
            m = -1;
            if (k == K_ALIGN || k == K_VERTICAL) begin
                for (int i = 0; i < NUM_VALS; i++)
                    if (m < 0 && vals_left[i] && val_words[i].len() == value_len &&
                        (k == K_ALIGN ? VAL_ALIGN_SET[i] : VAL_VERT_SET[i]))
                        m = i;
                // The align words are listed in the order of their codes.
                if (m >= 0 && k == K_ALIGN)
                    align_now = m;
                else if (m >= 0)
                    vertical_now = (m == V_LR) ? VERT_LR : VERT_RL;
            end else if (k == K_LINE) begin
                if (digits == 0)
                    return;
                if (pct_seen) begin
                    if (number <= 100) begin
                        line_now = number;
                        snap_now = 1'b0;
                    end
                end else begin
                    line_now = minus_seen ? -number : number;
                    snap_now = 1'b1;
                end
            end else if (k == K_SIZE || k == K_POSITION) begin
                if (digits == 0 || !pct_seen || number > 100)
                    return;
                if (k == K_SIZE)
                    size_now = number;
                else
                    position_now = number;
            end
        endfunction

        function void note_item(t_cue_in item);
            t_cue_out snap;
            if (item.func) begin
                restore();
                phase = PH_GAP;
            end else if (is_blank(item.char_byte)) begin
                close_word();
                phase = PH_GAP;
            end else begin
                if (phase == PH_GAP)
                    open_word();
                if (phase != PH_SKIP) begin
                    word_len++;
                    if (word_len > MAX_WORD)
                        phase = PH_SKIP;
                end
                if (phase == PH_KEY)
                    key_byte(item.char_byte, word_len - 1);
                else if (phase == PH_VALUE)
                    value_byte(item.char_byte);
                if (item.last)
                    close_word();
            end
            if (item.last) begin
                phase = PH_GAP;
                snap.out_line     = 16'(line_now);
                snap.out_snap     = snap_now;
                snap.out_size     = 7'(size_now);
                snap.out_position = 7'(position_now);
                snap.out_vertical = 2'(vertical_now);
                snap.out_align    = 3'(align_now);
                settings_due.push_back(snap);
            end
        endfunction

        function void check_settings(t_cue_out got);
            t_cue_out want;
            if (settings_due.size() == 0) begin
                faults++;
                if (faults <= 10)
                    $display("unexpected settings result: line %0d align %0d",
                             got.out_line, got.out_align);
                return;
            end
            want = settings_due.pop_front();
            if (got.out_line !== want.out_line || got.out_snap !== want.out_snap ||
                got.out_size !== want.out_size || got.out_position !== want.out_position ||
                got.out_vertical !== want.out_vertical || got.out_align !== want.out_align) begin
                faults++;
                if (faults <= 10)
                    $display({"settings mismatch (expected/actual): line %0d/%0d snap %0d/%0d",
                              " size %0d/%0d position %0d/%0d vertical %0d/%0d align %0d/%0d"},
                             want.out_line, got.out_line, want.out_snap, got.out_snap,
                             want.out_size, got.out_size, want.out_position, got.out_position,
                             want.out_vertical, got.out_vertical, want.out_align, got.out_align);
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_stall;
    t_cue_in             i_in_data   = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    t_cue_out            o_out_data;
    logic                psel        = 1'b0;
    logic                penable     = 1'b0;
    logic                pwrite      = 1'b0;
    logic [ADDR_W-1:0]   paddr       = '0;
    logic [DATA_W-1:0]   pwdata      = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    cue_settings_tracker tracker = new();

    // Items waiting to be offered to the block, built one string at a time.
    t_cue_in cue_items[$];

    // Random idling: each side switches now and then into a stretch without gaps.
    bit burst_in     = 1'b0;
    bit quiet_out    = 1'b0;
    // Set by the main sequence to ask the receiver for one long hold-off.
    bit hold_armed   = 1'b0;
    int stuck_cycles = 0;

    cue_settings_text_parser u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Both channels are sampled at the rising edge. Results are checked before
    // the input transfer of the same edge is noted; a result can never belong
    // to an item accepted at the same edge, so the order does not matter.
    // The same process watches for a run that has stopped moving.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall)
                tracker.check_settings(o_out_data);
            if (i_in_valid && !o_in_stall)
                tracker.note_item(i_in_data);
            if ((o_out_valid && !i_out_stall) || (i_in_valid && !o_in_stall))
                stuck_cycles <= 0;
            else
                stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("cue_settings_text_parser_test: errors");
                $finish;
            end
        end
    end

    // Receiver: before each result it stalls for a random number of cycles,
    // then keeps stall low until a result transfer has happened. Once, on
    // request, it holds off for a long stretch so that the result register
    // stays full and the block has to stall its input.
    initial begin
        int wait_cycles;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_armed) begin
                hold_armed = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end else begin
                if ($urandom_range(0, 15) == 0)
                    quiet_out = !quiet_out;
                wait_cycles = quiet_out ? 0 : $urandom_range(0, 7);
                i_out_stall <= (wait_cycles != 0);
                if (wait_cycles != 0) begin
                    repeat (wait_cycles) @(negedge i_clk);
                    i_out_stall <= 1'b0;
                end
            end
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    function automatic void put_byte(logic [7:0] b);
        t_cue_in item;
        item.func      = 1'b0;
        item.char_byte = b;
        item.last      = 1'b0;
        cue_items.push_back(item);
    endfunction

    function automatic void put_text(string s);
        for (int i = 0; i < s.len(); i++)
            put_byte(s[i]);
    endfunction

    // The byte of a restore is ignored by the block, so it is random.
    function automatic void put_restore(logic last);
        t_cue_in item;
        item.func      = 1'b1;
        item.char_byte = 8'($urandom_range(0, 255));
        item.last      = last;
        cue_items.push_back(item);
    endfunction

    function automatic void end_string();
        t_cue_in item;
        item = cue_items.pop_back();
        item.last = 1'b1;
        cue_items.push_back(item);
    endfunction

    function automatic void put_blank();
        logic [7:0] blanks[5];
        blanks = '{CH_SPACE, CH_TAB, CH_LF, CH_FF, CH_CR};
        repeat ($urandom_range(1, 2)) put_byte(blanks[$urandom_range(0, 4)]);
    endfunction

    // Mostly well-formed key:value words with random values, some of them
    // broken on purpose; the rest are near-miss keys and raw noise bytes.
    function automatic void put_random_word();
        int    pick;
        int    k;
        int    n;
        string txt;
        pick = $urandom_range(0, 99);
        k = $urandom_range(0, NUM_KEYS - 1);
        txt = tracker.key_words[k];
        if (pick < 70) begin
            txt = {txt, ":"};
            if (k == K_ALIGN || k == K_VERTICAL) begin
                if ($urandom_range(0, 5) == 0) begin
                    // Any value word, possibly of the other key, possibly run on.
                    txt = {txt, tracker.val_words[$urandom_range(0, NUM_VALS - 1)]};
                    if ($urandom_range(0, 1) == 0)
                        txt = {txt, "x"};
                end else if (k == K_ALIGN) begin
                    txt = {txt, tracker.val_words[$urandom_range(0, V_LR - 1)]};
                end else begin
                    txt = {txt, tracker.val_words[$urandom_range(V_LR, V_RL)]};
                end
            end else begin
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 99999)
                                                : $urandom_range(0, 120);
                if (k == K_LINE && $urandom_range(0, 3) == 0)
                    txt = {txt, "-"};
                txt = {txt, $sformatf("%0d", n)};
                if (k == K_LINE ? ($urandom_range(0, 2) == 0) : ($urandom_range(0, 7) != 0))
                    txt = {txt, "%"};
            end
            put_text(txt);
        end else if (pick < 85) begin
            case ($urandom_range(0, 2))
                0:       txt = {txt.substr(0, $urandom_range(0, txt.len() - 2)), ":5%"};
                1:       txt = {txt, "s:1"};
                default: txt = {txt, "1"};
            endcase
            put_text(txt);
        end else begin
            repeat ($urandom_range(1, 8)) put_byte(8'($urandom_range(0, 255)));
        end
    endfunction

    function automatic void put_random_string();
        int words;
        words = $urandom_range(1, 3);
        if ($urandom_range(0, 3) == 0)
            put_blank();
        for (int w = 0; w < words; w++) begin
            if (w != 0)
                put_blank();
            put_random_word();
            if ($urandom_range(0, 24) == 0)
                put_restore(1'b0);
        end
        if ($urandom_range(0, 3) == 0)
            put_blank();
        if ($urandom_range(0, 19) == 0)
            put_restore(1'b0);
        end_string();
    endfunction

    // Offers every queued item in turn with a random gap before each. Valid
    // stays high from one item to the next when there is no gap.
    task automatic send_items();
        t_cue_in item;
        int      gap;
        while (cue_items.size() != 0) begin
            item = cue_items.pop_front();
            if ($urandom_range(0, 15) == 0)
                burst_in = !burst_in;
            gap = burst_in ? 0 : $urandom_range(0, 7);
            repeat (gap) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
            end
            @(negedge i_clk);
            i_in_valid <= 1'b1;
            i_in_data  <= item;
            do @(posedge i_clk); while (o_in_stall);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    // Waits until every queued snapshot has been matched, then lets the
    // pipeline run empty, since a trailing item may cause no result.
    task automatic settle();
        while (tracker.pending() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        tracker.set_default(idx, data);
    endtask

    task automatic write_defaults(logic [15:0] line_dflt, logic snap_dflt,
                                  logic [6:0] position_dflt, logic [6:0] size_dflt,
                                  logic [1:0] vertical_dflt, logic [2:0] align_dflt);
        write_reg(REG_LINE,     {16'h0, line_dflt});
        write_reg(REG_SNAP,     {31'h0, snap_dflt});
        write_reg(REG_POSITION, {25'h0, position_dflt});
        write_reg(REG_SIZE,     {25'h0, size_dflt});
        write_reg(REG_VERTICAL, {30'h0, vertical_dflt});
        write_reg(REG_ALIGN,    {29'h0, align_dflt});
    endtask

    // A phase of random strings. It opens with a restore that reports the
    // freshly loaded defaults.
    task automatic random_phase(int min_bytes, int min_strings);
        int strings;
        strings = 0;
        put_restore(1'b1);
        while (cue_items.size() < min_bytes || strings < min_strings) begin
            put_random_string();
            strings++;
        end
        send_items();
        settle();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed strings under the reset defaults.
        put_text("align:start");
        end_string();
        // Negative line, both percent keys and a vertical word in one string.
        put_text("line:-5 position:10% size:100%");
        put_byte(CH_TAB);
        put_text("vertical:rl");
        end_string();
        // Line in percent clears snap; line feed, form feed, carriage return and space separate words.
        put_text("line:42%");
        put_byte(CH_LF);
        put_text("align:end");
        put_byte(CH_FF);
        put_text("align:left");
        put_byte(CH_CR);
        put_text("vertical:lr align:right");
        end_string();
        // Values against the rules leave everything as it was.
        put_text("line:-7% line:101% size:50 position:%5 line:5%% line:- line:5- size:101%");
        end_string();
        // Big numbers saturate in magnitude.
        put_text("line:99999999 size:99999%");
        end_string();
        put_text("line:-123456");
        end_string();
        // No colon, empty key, unknown key, empty value, run-on and cut-short values.
        put_text("nocolon :x alignx:start align: vertical:lrx align:mid");
        end_string();
        // NUL and 0xFF are ordinary word bytes.
        put_text("al");
        put_byte(8'h00);
        put_text("ign:end align:");
        put_byte(8'hFF);
        put_byte(CH_SPACE);
        put_text("align:middle");
        put_byte(8'hFF);
        end_string();
        put_text("position:0% size:0% line:0 line:100%");
        end_string();
        // A restore drops the word in progress, so the trailing byte starts a new one.
        put_text("align:en");
        put_restore(1'b0);
        put_text("d");
        end_string();
        put_restore(1'b1);
        // A string of whitespace only, and a string that ends on a blank.
        put_byte(CH_TAB);
        end_string();
        put_text("vertical:rl ");
        end_string();
        // A word of exactly the longest length is parsed; one byte more is skipped.
        put_text("line:");
        repeat (MAX_WORD - 5) put_byte(CH_ZERO + 8'd7);
        end_string();
        put_text("line:1 line:");
        repeat (MAX_WORD - 4) put_byte(CH_ZERO + 8'd3);
        end_string();
        send_items();
        settle();

        // Out-of-range position, size, vertical and align defaults; the most negative line is clamped.
        write_defaults(LINE_MIN_RAW, 1'b1, PCT_BAD, PCT_BAD, VERT_BAD, ALIGN_BAD);
        random_phase(30, 2);

        // Largest line with snap clear is illegal and must not load. This phase
        // also carries the receiver's long hold-off.
        write_defaults(16'sd32767, 1'b0, PCT7_MAX, 7'd0, VERT_RL, ALIGN_MAX);
        hold_armed = 1'b1;
        random_phase(60, 5);

        write_defaults(16'sd100, 1'b0, 7'd0, PCT7_MAX + 7'd1, VERT_LR, ALIGN_START);
        random_phase(30, 2);

        repeat (2) begin
            write_defaults(($urandom_range(0, 1) == 0) ? 16'($urandom) : 16'($urandom_range(0, 100)),
                           1'($urandom), 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                           2'($urandom), 3'($urandom));
            random_phase(30, 2);
        end

        if (tracker.faults == 0)
            $display("cue_settings_text_parser_test: clean");
        else
            $display("cue_settings_text_parser_test: errors");
        $finish;
    end

endmodule
